// File: design/fsb64_pkg.sv
// Shared constants, types and symbol lookup for the field-split base64 decoder.
package fsb64_pkg;

    localparam int FIELD_BYTES = 64;
    localparam int MAX_FIELDS  = 15;
    localparam int FPOS_W      = $clog2(FIELD_BYTES);

    localparam int BUNDLE_DEPTH = 4;
    localparam int PTR_W        = $clog2(BUNDLE_DEPTH);
    localparam int CNT_W        = $clog2(BUNDLE_DEPTH + 1);

    localparam logic [6:0] PAD_SYM = 7'd64;

    typedef enum logic [0:0] {
        CFG_NUM_FIELDS  = 1'b0,
        CFG_MAX_PAYLOAD = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_FIELD_BYTE = 3'd0,
        KIND_FIELD_END  = 3'd1,
        KIND_PAYLOAD    = 3'd2,
        KIND_DONE       = 3'd3,
        KIND_ERROR      = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ERR_FIELDS_INCOMPLETE = 3'd0,
        ERR_FIELD_LONG        = 3'd1,
        ERR_AFTER_PAD         = 3'd2,
        ERR_BAD_CHAR          = 3'd3,
        ERR_BAD_PAD           = 3'd4,
        ERR_TOO_LARGE         = 3'd5,
        ERR_TRUNCATED         = 3'd6
    } t_err;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] field_index;
        logic [7:0] data_byte;
        t_err       error_code;
    } t_result;

    // All results caused by one input beat; len is used only by a done result.
    typedef struct packed {
        logic [1:0]  cnt;
        t_result [2:0] res;
        logic [23:0] len;
    } t_bundle;

    // Bit 7 set: not a base64 symbol. Otherwise the 6-bit value, or PAD_SYM.
    function automatic logic [7:0] sym_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'hFF;
        if (c inside {["A":"Z"]}) begin
            v = c - 8'd65;
        end else if (c inside {["a":"z"]}) begin
            v = c - 8'd97 + 8'd26;
        end else if (c inside {["0":"9"]}) begin
            v = c - 8'd48 + 8'd52;
        end else if (c inside {"+", "-"}) begin
            v = 8'd62;
        end else if (c inside {"/", "_"}) begin
            v = 8'd63;
        end else if (c == "=") begin
            v = {1'b0, PAD_SYM};
        end
        return v;
    endfunction

endpackage

// File: design/field_split_base64_decoder.sv
// Top level: field splitter and base64 decoder with a result bundle queue.
// Flow: a beat is registered, decoded from the input register and pushed as one bundle into
// the queue; the head of the queue drives the outputs.
// Throughput: one beat per cycle while the queue has room; a beat with k results offers them
// in turn, and a 4-deep bundle queue absorbs bursts before the input stalls.
// Reset: synchronous, active low; clears request state and queue, one text field, 64 KiB cap.
module field_split_base64_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_out_kind,
    output logic [3:0]  o_field_index,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_error_code,
    output logic [23:0] o_payload_length,
    output logic        o_last_of_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    typedef enum logic [1:0] {
        PH_FIELDS  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } t_phase;

    // configuration
    logic [3:0]  r_num_fields;
    logic [23:0] r_max_payload;

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_eoi;

    // request state
    t_phase                   r_phase, n_phase;
    logic [3:0]               r_cur_field, n_cur_field;
    logic [fsb64_pkg::FPOS_W-1:0] r_field_pos, n_field_pos;
    logic [1:0]               r_sym_held, n_sym_held;
    logic [2:0][6:0]          r_held, n_held;
    logic                     r_pad_seen, n_pad_seen;
    logic [23:0]              r_decoded, n_decoded;

    // bundle queue
    fsb64_pkg::t_bundle r_fifo [fsb64_pkg::BUNDLE_DEPTH];
    logic [fsb64_pkg::PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [fsb64_pkg::CNT_W-1:0] r_count;
    logic [1:0]                  r_sub;

    fsb64_pkg::t_bundle bnd;
    fsb64_pkg::t_bundle head;
    fsb64_pkg::t_result head_res;
    logic in_acc, proc, push, out_acc, pop, can_push;

    assign o_cfg_ready = 1'b1;

    // ---------------- decode of the registered beat ----------------
    always_comb begin
        logic [3:0]  fc;
        logic [7:0]  sv;
        logic [6:0]  v, s0, s1, s2;
        logic [2:0][7:0] bytes;
        logic [1:0]  wants, nok, nemit;
        logic        ok0, ok1, ok2, short_cap;
        logic [24:0] dec_ext, max_ext;

        n_phase     = r_phase;
        n_cur_field = r_cur_field;
        n_field_pos = r_field_pos;
        n_sym_held  = r_sym_held;
        n_held      = r_held;
        n_pad_seen  = r_pad_seen;
        n_decoded   = r_decoded;
        bnd         = '0;

        fc = r_num_fields;
        if (fc == 4'd0) begin
            fc = 4'd1;
        end else if ({28'd0, fc} > fsb64_pkg::MAX_FIELDS) begin
            fc = 4'(fsb64_pkg::MAX_FIELDS);
        end

        sv = fsb64_pkg::sym_value(r_in_byte);
        v  = sv[6:0];
        s0 = r_held[0];
        s1 = r_held[1];
        s2 = r_held[2];
        bytes[0] = {s0[5:0], s1[5:4]};
        bytes[1] = {s1[3:0], s2[5:2]};
        bytes[2] = {s2[1:0], v[5:0]};

        dec_ext = {1'b0, r_decoded};
        max_ext = {1'b0, r_max_payload};
        ok0 = dec_ext < max_ext;
        ok1 = (dec_ext + 25'd1) < max_ext;
        ok2 = (dec_ext + 25'd2) < max_ext;
        nok = ok2 ? 2'd3 : (ok1 ? 2'd2 : (ok0 ? 2'd1 : 2'd0));
        if (s2 == fsb64_pkg::PAD_SYM) begin
            wants = 2'd1;
        end else if (v == fsb64_pkg::PAD_SYM) begin
            wants = 2'd2;
        end else begin
            wants = 2'd3;
        end
        short_cap = nok < wants;
        nemit     = short_cap ? nok : wants;

        if (r_in_eoi) begin
            case (r_phase)
                PH_FIELDS: begin
                    bnd.cnt               = 2'd1;
                    bnd.res[0].kind       = fsb64_pkg::KIND_ERROR;
                    bnd.res[0].error_code = fsb64_pkg::ERR_FIELDS_INCOMPLETE;
                end
                PH_PAYLOAD: begin
                    bnd.cnt = 2'd1;
                    if (r_sym_held != 2'd0) begin
                        bnd.res[0].kind       = fsb64_pkg::KIND_ERROR;
                        bnd.res[0].error_code = fsb64_pkg::ERR_TRUNCATED;
                    end else begin
                        bnd.res[0].kind = fsb64_pkg::KIND_DONE;
                        bnd.len         = r_decoded;
                    end
                end
                default: begin
                end
            endcase
            // start a new request
            n_phase     = PH_FIELDS;
            n_cur_field = '0;
            n_field_pos = '0;
            n_sym_held  = '0;
            n_held      = '0;
            n_pad_seen  = 1'b0;
            n_decoded   = '0;
        end else begin
            case (r_phase)
                PH_FIELDS: begin
                    bnd.cnt = 2'd1;
                    if (r_in_byte == ",") begin
                        bnd.res[0].kind        = fsb64_pkg::KIND_FIELD_END;
                        bnd.res[0].field_index = r_cur_field;
                        n_cur_field            = r_cur_field + 4'd1;
                        n_field_pos            = '0;
                        if (n_cur_field >= fc) begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else if (r_field_pos ==
                                 fsb64_pkg::FPOS_W'(fsb64_pkg::FIELD_BYTES - 1)) begin
                        bnd.res[0].kind       = fsb64_pkg::KIND_ERROR;
                        bnd.res[0].error_code = fsb64_pkg::ERR_FIELD_LONG;
                        n_phase               = PH_DROP;
                    end else begin
                        bnd.res[0].kind        = fsb64_pkg::KIND_FIELD_BYTE;
                        bnd.res[0].field_index = r_cur_field;
                        bnd.res[0].data_byte   = r_in_byte;
                        n_field_pos            = r_field_pos + fsb64_pkg::FPOS_W'(1);
                    end
                end
                PH_PAYLOAD: begin
                    if (r_in_byte inside {8'd32, [8'd9:8'd13]}) begin
                        // skip whitespace
                    end else if (r_pad_seen) begin
                        bnd.cnt               = 2'd1;
                        bnd.res[0].kind       = fsb64_pkg::KIND_ERROR;
                        bnd.res[0].error_code = fsb64_pkg::ERR_AFTER_PAD;
                        n_phase               = PH_DROP;
                    end else if (sv[7]) begin
                        bnd.cnt               = 2'd1;
                        bnd.res[0].kind       = fsb64_pkg::KIND_ERROR;
                        bnd.res[0].error_code = fsb64_pkg::ERR_BAD_CHAR;
                        n_phase               = PH_DROP;
                    end else if (r_sym_held != 2'd3) begin
                        n_held[r_sym_held] = v;
                        n_sym_held         = r_sym_held + 2'd1;
                    end else begin
                        n_sym_held = 2'd0;
                        if (s0 == fsb64_pkg::PAD_SYM || s1 == fsb64_pkg::PAD_SYM ||
                            (s2 == fsb64_pkg::PAD_SYM && v != fsb64_pkg::PAD_SYM)) begin
                            bnd.cnt               = 2'd1;
                            bnd.res[0].kind       = fsb64_pkg::KIND_ERROR;
                            bnd.res[0].error_code = fsb64_pkg::ERR_BAD_PAD;
                            n_phase               = PH_DROP;
                        end else begin
                            for (int k = 0; k < 3; k++) begin
                                if (2'(k) < nemit) begin
                                    bnd.res[k].kind      = fsb64_pkg::KIND_PAYLOAD;
                                    bnd.res[k].data_byte = bytes[k];
                                end
                            end
                            n_decoded = r_decoded + {22'd0, nemit};
                            if (short_cap) begin
                                // cap hit: error follows the bytes already sent
                                bnd.res[nemit].kind       = fsb64_pkg::KIND_ERROR;
                                bnd.res[nemit].error_code = fsb64_pkg::ERR_TOO_LARGE;
                                bnd.cnt                   = nemit + 2'd1;
                                n_phase                   = PH_DROP;
                            end else begin
                                bnd.cnt = nemit;
                                if (wants != 2'd3) begin
                                    n_pad_seen = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: begin
                    // drop bytes until end of input
                end
            endcase
        end
    end

    // ---------------- handshakes ----------------
    assign head     = r_fifo[r_rd_ptr];
    assign head_res = head.res[r_sub];

    assign o_out_valid = r_count != '0;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign pop         = out_acc && (r_sub == head.cnt - 2'd1);
    assign can_push    = (r_count != fsb64_pkg::CNT_W'(fsb64_pkg::BUNDLE_DEPTH)) || pop;
    assign proc        = r_in_vld && can_push;
    assign push        = proc && (bnd.cnt != 2'd0);
    assign o_in_stall  = r_in_vld && !can_push;
    assign in_acc      = i_in_valid && !o_in_stall;

    assign o_out_kind       = head_res.kind;
    assign o_field_index    = head_res.field_index;
    assign o_data_byte      = head_res.data_byte;
    assign o_error_code     = head_res.error_code;
    assign o_payload_length = (head_res.kind == fsb64_pkg::KIND_DONE) ? head.len : 24'd0;
    assign o_last_of_item   = o_out_valid && (r_sub == head.cnt - 2'd1);

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_in_byte;
            r_in_eoi  <= i_end_of_input;
        end
        if (push) begin
            r_fifo[r_wr_ptr] <= bnd;
        end
        if (!i_rst_n) begin
            r_num_fields  <= 4'd1;
            r_max_payload <= 24'h010000;
            r_in_vld      <= 1'b0;
            r_phase       <= PH_FIELDS;
            r_cur_field   <= '0;
            r_field_pos   <= '0;
            r_sym_held    <= '0;
            r_held        <= '0;
            r_pad_seen    <= 1'b0;
            r_decoded     <= '0;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
            r_sub         <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    fsb64_pkg::CFG_NUM_FIELDS:  r_num_fields  <= i_cfg_data[3:0];
                    fsb64_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (proc) begin
                r_in_vld <= 1'b0;
            end
            if (proc) begin
                r_phase     <= n_phase;
                r_cur_field <= n_cur_field;
                r_field_pos <= n_field_pos;
                r_sym_held  <= n_sym_held;
                r_held      <= n_held;
                r_pad_seen  <= n_pad_seen;
                r_decoded   <= n_decoded;
            end
            if (push) begin
                r_wr_ptr <= r_wr_ptr + fsb64_pkg::PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + fsb64_pkg::PTR_W'(1);
                r_sub    <= '0;
            end else if (out_acc) begin
                r_sub <= r_sub + 2'd1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + fsb64_pkg::CNT_W'(1);
                2'b01:   r_count <= r_count - fsb64_pkg::CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: tb/field_split_base64_decoder_tb.sv
// Self-checking testbench for the field-split base64 decoder: directed table, random requests.
module field_split_base64_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS  = 330;
    localparam int CONFIG_SETS   = 6;
    localparam int SETTLE_CYCLES = 4;
    // code field reads zero off errors
    localparam fsb64_pkg::t_err NO_ERROR = fsb64_pkg::ERR_FIELDS_INCOMPLETE;

    typedef enum logic [1:0] {
        REQ_FIELDS,
        REQ_PAYLOAD,
        REQ_DROP
    } t_req_phase;

    typedef struct packed {
        fsb64_pkg::t_kind kind;
        logic [3:0]       field_index;
        logic [7:0]       data_byte;
        fsb64_pkg::t_err  error_code;
        logic [23:0]      payload_length;
        logic             last_of_item;
    } t_decoder_result;

    typedef struct packed {
        logic [7:0]      in_byte;
        logic            end_of_input;
        logic            typed;
        t_decoder_result result;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_end_of_input = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_out_kind;
    logic [3:0]  o_field_index;
    logic [7:0]  o_data_byte;
    logic [2:0]  o_error_code;
    logic [23:0] o_payload_length;
    logic        o_last_of_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = fsb64_pkg::CFG_NUM_FIELDS;
    logic [23:0] i_cfg_data = 24'd0;

    field_split_base64_decoder i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_byte        (i_in_byte),
        .i_end_of_input   (i_end_of_input),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_kind       (o_out_kind),
        .o_field_index    (o_field_index),
        .o_data_byte      (o_data_byte),
        .o_error_code     (o_error_code),
        .o_payload_length (o_payload_length),
        .o_last_of_item   (o_last_of_item),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Decoder state as the testbench tracks it
    logic [3:0]  cfg_fields = 4'd1;
    logic [23:0] cfg_cap = 24'd65536;
    t_req_phase  req_phase;
    logic [3:0]  cur_field;
    int          field_pos;
    int          held_cnt;
    int          held[3];
    bit          pad_seen;
    logic [23:0] byte_count;

    t_decoder_result beat_results[$];
    t_decoder_result awaited_results[$];
    t_decoder_result oldest;
    t_directed_row   directed_rows[$];
    logic [8:0]      request_bytes[$];

    int  mismatches = 0;
    int  results_checked = 0;
    int  beats_in = 0;
    int  requests = 0;
    int  done_seen = 0;
    int  error_seen = 0;
    bit  no_gaps = 1'b0;
    int  stall_run = 0;
    bit  stall_on = 1'b0;

    int phase_fields[CONFIG_SETS] = '{2, 15, 0, 1, 3, 1};
    int phase_caps[CONFIG_SETS]   = '{24'hFFFFFF, 7, 0, 1, 40, 65536};

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("field_split_base64_decoder_tb failed");
        $finish;
    end

    function automatic void restart_request();
        req_phase  = REQ_FIELDS;
        cur_field  = 4'd0;
        field_pos  = 0;
        held_cnt   = 0;
        held       = '{0, 0, 0};
        pad_seen   = 1'b0;
        byte_count = 24'd0;
    endfunction

    function automatic void add_result(fsb64_pkg::t_kind k, logic [3:0] idx, logic [7:0] d,
                                       fsb64_pkg::t_err e, logic [23:0] len);
        t_decoder_result r;
        r.kind           = k;
        r.field_index    = idx;
        r.data_byte      = d;
        r.error_code     = e;
        r.payload_length = len;
        r.last_of_item   = 1'b0;
        beat_results.push_back(r);
    endfunction

    function automatic void abort_request(fsb64_pkg::t_err e);
        add_result(fsb64_pkg::KIND_ERROR, 4'd0, 8'h00, e, 24'd0);
        req_phase = REQ_DROP;
    endfunction

    function automatic bit emit_payload_byte(logic [7:0] d);
        if (byte_count >= cfg_cap) begin
            abort_request(fsb64_pkg::ERR_TOO_LARGE);
            return 1'b0;
        end
        add_result(fsb64_pkg::KIND_PAYLOAD, 4'd0, d, NO_ERROR, 24'd0);
        byte_count = byte_count + 24'd1;
        return 1'b1;
    endfunction

    // -1 for a byte outside both alphabets
    function automatic int symbol_value(logic [7:0] c);
        if (c inside {["A":"Z"]}) return c - "A";
        if (c inside {["a":"z"]}) return c - "a" + 26;
        if (c inside {["0":"9"]}) return c - "0" + 52;
        if (c inside {"+", "-"}) return 62;
        if (c inside {"/", "_"}) return 63;
        if (c == "=") return fsb64_pkg::PAD_SYM;
        return -1;
    endfunction

    function automatic logic [7:0] symbol_char(int v, bit url);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        if (v == 62) return url ? "-" : "+";
        return url ? "_" : "/";
    endfunction

    function automatic void take_payload_char(logic [7:0] c);
        int v, s0, s1, s2;
        if (c inside {8'd32, [8'd9:8'd13]}) return;
        if (pad_seen) begin
            abort_request(fsb64_pkg::ERR_AFTER_PAD);
            return;
        end
        v = symbol_value(c);
        if (v < 0) begin
            abort_request(fsb64_pkg::ERR_BAD_CHAR);
            return;
        end
        if (held_cnt < 3) begin
            held[held_cnt] = v;
            held_cnt++;
            return;
        end
        s0 = held[0];
        s1 = held[1];
        s2 = held[2];
        held_cnt = 0;
        if (s0 == fsb64_pkg::PAD_SYM || s1 == fsb64_pkg::PAD_SYM ||
            (s2 == fsb64_pkg::PAD_SYM && v != fsb64_pkg::PAD_SYM)) begin
            abort_request(fsb64_pkg::ERR_BAD_PAD);
            return;
        end
        if (!emit_payload_byte({s0[5:0], s1[5:4]})) return;
        if (s2 == fsb64_pkg::PAD_SYM) begin
            pad_seen = 1'b1;
            return;
        end
        if (!emit_payload_byte({s1[3:0], s2[5:2]})) return;
        if (v == fsb64_pkg::PAD_SYM) begin
            pad_seen = 1'b1;
            return;
        end
        void'(emit_payload_byte({s2[1:0], v[5:0]}));
    endfunction

    // Work out every result that one accepted beat causes
    function automatic void split_and_decode(logic [7:0] c, logic eoi);
        int fc_eff;
        fc_eff = (cfg_fields == 4'd0) ? 1 : int'(cfg_fields);
        beat_results.delete();
        if (eoi) begin
            if (req_phase == REQ_FIELDS) begin
                add_result(fsb64_pkg::KIND_ERROR, 4'd0, 8'h00,
                           fsb64_pkg::ERR_FIELDS_INCOMPLETE, 24'd0);
            end else if (req_phase == REQ_PAYLOAD) begin
                if (held_cnt != 0) begin
                    add_result(fsb64_pkg::KIND_ERROR, 4'd0, 8'h00,
                               fsb64_pkg::ERR_TRUNCATED, 24'd0);
                end else begin
                    add_result(fsb64_pkg::KIND_DONE, 4'd0, 8'h00, NO_ERROR, byte_count);
                end
            end
            restart_request();
        end else if (req_phase == REQ_FIELDS) begin
            if (c == ",") begin
                add_result(fsb64_pkg::KIND_FIELD_END, cur_field, 8'h00, NO_ERROR, 24'd0);
                cur_field = cur_field + 4'd1;
                field_pos = 0;
                if (cur_field >= fc_eff) req_phase = REQ_PAYLOAD;
            end else if (field_pos + 1 >= fsb64_pkg::FIELD_BYTES) begin
                abort_request(fsb64_pkg::ERR_FIELD_LONG);
            end else begin
                add_result(fsb64_pkg::KIND_FIELD_BYTE, cur_field, c, NO_ERROR, 24'd0);
                field_pos++;
            end
        end else if (req_phase == REQ_PAYLOAD) begin
            take_payload_char(c);
        end
        if (beat_results.size() > 0) beat_results[$].last_of_item = 1'b1;
    endfunction

    function automatic void plain_row(logic [7:0] b, logic eoi);
        t_directed_row row;
        row = '0;
        row.in_byte      = b;
        row.end_of_input = eoi;
        directed_rows.push_back(row);
    endfunction

    function automatic void typed_row(logic [7:0] b, logic eoi, fsb64_pkg::t_kind k,
                                      logic [3:0] idx, logic [7:0] d, fsb64_pkg::t_err e,
                                      logic [23:0] len);
        t_directed_row row;
        row.in_byte                = b;
        row.end_of_input           = eoi;
        row.typed                  = 1'b1;
        row.result.kind            = k;
        row.result.field_index     = idx;
        row.result.data_byte       = d;
        row.result.error_code      = e;
        row.result.payload_length  = len;
        row.result.last_of_item    = 1'b1;
        directed_rows.push_back(row);
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic eoi, input bit typed,
                             input t_decoder_result typed_result);
        int gap, r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) gap = 0;
        else if (r < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 30);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in_byte      <= b;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        beats_in++;
        split_and_decode(b, eoi);
        if (typed) begin
            beat_results.delete();
            beat_results.push_back(typed_result);
        end
        foreach (beat_results[k]) awaited_results.push_back(beat_results[k]);
    endtask

    // Hold the sender until every awaited result is out, then let the pipe settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_registers(input logic [3:0] fc, input logic [23:0] cap);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= fsb64_pkg::CFG_NUM_FIELDS;
        i_cfg_data  <= {20'd0, fc};
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        cfg_fields = fc;
        i_cfg_index <= fsb64_pkg::CFG_MAX_PAYLOAD;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        cfg_cap = cap;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic build_request(input bit with_long);
        int fc_eff, nf, len, ngroups, style, npad, badpos, w;
        logic [7:0] b;
        request_bytes.delete();
        fc_eff = (cfg_fields == 4'd0) ? 1 : int'(cfg_fields);
        style  = with_long ? 19 : $urandom_range(0, 19);
        if (style == 0) begin
            // pure noise
            repeat ($urandom_range(1, 12)) request_bytes.push_back({1'b0, 8'($urandom)});
        end else begin
            nf = (style == 1) ? $urandom_range(0, fc_eff - 1) : fc_eff;
            for (int f = 0; f < nf; f++) begin
                if (with_long && f == 0) len = fsb64_pkg::FIELD_BYTES + $urandom_range(0, 2);
                else if ($urandom_range(0, 39) == 0)
                    len = $urandom_range(fsb64_pkg::FIELD_BYTES - 4,
                                         fsb64_pkg::FIELD_BYTES + 2);
                else len = $urandom_range(0, 4);
                repeat (len) begin
                    b = 8'($urandom);
                    if (b == ",") b = ";";
                    request_bytes.push_back({1'b0, b});
                end
                request_bytes.push_back({1'b0, 8'(",")});
            end
            if (nf == fc_eff) begin
                ngroups = $urandom_range(0, 4);
                npad    = (style == 5) ? 0 : $urandom_range(0, 2);
                badpos  = (style == 5) ? $urandom_range(0, 2) : 4;
                for (int g = 0; g < ngroups; g++) begin
                    for (int k = 0; k < 4; k++) begin
                        if ($urandom_range(0, 9) == 0) begin
                            w = $urandom_range(8, 13);
                            request_bytes.push_back({1'b0, (w == 8) ? 8'(" ") : 8'(w)});
                        end
                        if (style == 3 && $urandom_range(0, 5) == 0) b = 8'($urandom);
                        else if (g == ngroups - 1 && (k == badpos || k >= 4 - npad)) b = "=";
                        else b = symbol_char($urandom_range(0, 63), $urandom_range(0, 1));
                        request_bytes.push_back({1'b0, b});
                    end
                end
                // cut the last group short
                if (style == 2 && ngroups > 0)
                    repeat ($urandom_range(1, 3)) void'(request_bytes.pop_back());
                if (style == 4)
                    request_bytes.push_back({1'b0,
                        symbol_char($urandom_range(0, 63), $urandom_range(0, 1))});
            end
        end
        request_bytes.push_back({1'b1, 8'($urandom)});
    endtask

    // Check results and drive the receiver's stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result: kind %0d idx %0d data %02h err %0d len %0d",
                         $time, o_out_kind, o_field_index, o_data_byte, o_error_code,
                         o_payload_length);
                mismatches++;
            end else begin
                oldest = awaited_results.pop_front();
                results_checked++;
                if (o_out_kind !== oldest.kind || o_field_index !== oldest.field_index ||
                    o_data_byte !== oldest.data_byte || o_error_code !== oldest.error_code ||
                    o_payload_length !== oldest.payload_length ||
                    o_last_of_item !== oldest.last_of_item) begin
                    $display({"%0t: mismatch: expected kind %0d idx %0d data %02h",
                              " err %0d len %0d last %0b"},
                             $time, oldest.kind, oldest.field_index, oldest.data_byte,
                             oldest.error_code, oldest.payload_length, oldest.last_of_item);
                    $display({"%0t:           actual kind %0d idx %0d data %02h",
                              " err %0d len %0d last %0b"},
                             $time, o_out_kind, o_field_index, o_data_byte, o_error_code,
                             o_payload_length, o_last_of_item);
                    mismatches++;
                end
                if (oldest.kind == fsb64_pkg::KIND_DONE) done_seen++;
                if (oldest.kind == fsb64_pkg::KIND_ERROR) error_seen++;
            end
        end
        if (stall_run > 0) begin
            stall_run--;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    stall_on  = 1'b0;
                    stall_run = $urandom_range(1, 25);
                end
                6, 7, 8: begin
                    stall_on  = 1'b1;
                    stall_run = $urandom_range(1, 3);
                end
                default: begin
                    stall_on  = 1'b1;
                    stall_run = $urandom_range(15, 40);
                end
            endcase
        end
        i_out_stall <= stall_on;
    end

    initial begin
        int random_start, req_in_phase;
        restart_request();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, run at the reset register values
        typed_row(8'hA5, 1'b1, fsb64_pkg::KIND_ERROR, 4'd0, 8'h00,
                  fsb64_pkg::ERR_FIELDS_INCOMPLETE, 24'd0);
        typed_row(8'h00, 1'b0, fsb64_pkg::KIND_FIELD_BYTE, 4'd0, 8'h00, NO_ERROR, 24'd0);
        typed_row(8'hFF, 1'b0, fsb64_pkg::KIND_FIELD_BYTE, 4'd0, 8'hFF, NO_ERROR, 24'd0);
        typed_row(",",   1'b0, fsb64_pkg::KIND_FIELD_END, 4'd0, 8'h00, NO_ERROR, 24'd0);
        plain_row("T", 1'b0);
        plain_row("W", 1'b0);
        plain_row("F", 1'b0);
        plain_row("u", 1'b0);
        plain_row("-", 1'b0);
        plain_row("_", 1'b0);
        plain_row("8", 1'b0);
        plain_row("=", 1'b0);
        typed_row("A",   1'b0, fsb64_pkg::KIND_ERROR, 4'd0, 8'h00,
                  fsb64_pkg::ERR_AFTER_PAD, 24'd0);
        plain_row("x",   1'b0);
        plain_row(8'h00, 1'b1);
        typed_row(",",   1'b0, fsb64_pkg::KIND_FIELD_END, 4'd0, 8'h00, NO_ERROR, 24'd0);
        plain_row("Q",   1'b0);
        typed_row(8'hFF, 1'b1, fsb64_pkg::KIND_ERROR, 4'd0, 8'h00,
                  fsb64_pkg::ERR_TRUNCATED, 24'd0);
        typed_row(",",   1'b0, fsb64_pkg::KIND_FIELD_END, 4'd0, 8'h00, NO_ERROR, 24'd0);
        typed_row("*",   1'b0, fsb64_pkg::KIND_ERROR, 4'd0, 8'h00,
                  fsb64_pkg::ERR_BAD_CHAR, 24'd0);
        plain_row(8'h00, 1'b1);
        typed_row(",",   1'b0, fsb64_pkg::KIND_FIELD_END, 4'd0, 8'h00, NO_ERROR, 24'd0);
        plain_row("A",   1'b0);
        plain_row("=",   1'b0);
        plain_row("A",   1'b0);
        typed_row("A",   1'b0, fsb64_pkg::KIND_ERROR, 4'd0, 8'h00,
                  fsb64_pkg::ERR_BAD_PAD, 24'd0);
        plain_row(8'h00, 1'b1);
        typed_row(",",   1'b0, fsb64_pkg::KIND_FIELD_END, 4'd0, 8'h00, NO_ERROR, 24'd0);
        typed_row(8'h5A, 1'b1, fsb64_pkg::KIND_DONE, 4'd0, 8'h00, NO_ERROR, 24'd0);

        foreach (directed_rows[k])
            send_beat(directed_rows[k].in_byte, directed_rows[k].end_of_input,
                      directed_rows[k].typed, directed_rows[k].result);
        drain();

        random_start = beats_in;
        for (int p = 0; p < CONFIG_SETS; p++) begin
            write_registers(4'(phase_fields[p]), 24'(phase_caps[p]));
            req_in_phase = 0;
            while (beats_in - random_start < (p + 1) * RANDOM_BEATS / CONFIG_SETS) begin
                build_request(p == 0 && req_in_phase == 0);
                no_gaps = ($urandom_range(0, 3) == 0);
                foreach (request_bytes[k])
                    send_beat(request_bytes[k][7:0], request_bytes[k][8], 1'b0, '0);
                requests++;
                req_in_phase++;
                if (req_in_phase == 2) drain();
            end
            drain();
        end

        $display("%0d beats in %0d random requests plus a directed table, %0d results checked",
                 beats_in, requests, results_checked);
        $display("%0d register settings, %0d requests done cleanly, %0d ended in error",
                 CONFIG_SETS + 1, done_seen, error_seen);
        if (mismatches == 0) begin
            $display("field_split_base64_decoder_tb passed");
        end else begin
            $display("field_split_base64_decoder_tb failed");
        end
        $finish;
    end

endmodule
